### rtl/core/bbd_pkg.sv
// Shared types, constants and helpers for the bilinear Bayer demosaic block.
// No dependencies; imported by every module of the block except bbd_ram.
package bbd_pkg;

   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT = 2048;
   localparam int DIM_W      = 12;
   localparam int PIX_W      = 8;
   localparam int ADDR_W     = $clog2(MAX_WIDTH);
   localparam int LINE_W     = 2 * PIX_W;

   // Request kind carried in tuser.
   localparam logic KIND_RAW   = 1'b0;
   localparam logic KIND_FLUSH = 1'b1;

   // Register indexes of the control port.
   localparam logic REG_FRAME_WIDTH  = 1'b0;
   localparam logic REG_FRAME_HEIGHT = 1'b1;

   typedef logic [PIX_W-1:0] pix_type;
   typedef logic [DIM_W-1:0] dim_type;

   // Window indexed [column][row]; column 0 is the left, row 0 the top.
   typedef logic [2:0][2:0][PIX_W-1:0] win_type;

   // Decoded request handed from position tracking to the interpolator.
   typedef struct packed {
      logic              keep;     // request updates state (not an ignored flush)
      logic              drain;    // frame fully input, sample reads as zero
      logic              emit;     // this request produces a pixel
      logic              eof;      // produced pixel is the last of the frame
      logic              rodd;
      logic              codd;
      logic              top;
      logic              bottom;
      logic              left;
      logic              right;
      logic              addr_ok;
      logic [ADDR_W-1:0] addr;
      pix_type           sample;
   } item_type;

   function automatic dim_type clamp_dim(input dim_type v, input int maxv);
      dim_type r;
      r = v;
      if (v < DIM_W'(2)) begin
         r = DIM_W'(2);
      end else if (32'(v) > maxv) begin
         r = DIM_W'(maxv);
      end
      return r;
   endfunction

endpackage

### rtl/core/bbd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds both line stores of the demosaic block in one instance.
module bbd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/bbd_ctrl.sv
// Input position tracking: row/column counters, edge flags and request decode.
// Depends on bbd_pkg.
module bbd_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  bbd_pkg::dim_type  frame_width,
   input  bbd_pkg::dim_type  frame_height,
   input  logic              accept,
   input  logic              kind,
   input  bbd_pkg::pix_type  sample,
   output bbd_pkg::item_type item
);
   import bbd_pkg::*;

   dim_type row_ff, row_in;
   dim_type col_ff, col_in;
   dim_type w, h;
   dim_type er, ec;
   logic    pre, post, wrap;

   always_comb begin
      w = clamp_dim(frame_width, MAX_WIDTH);
      h = clamp_dim(frame_height, MAX_HEIGHT);

      item.drain = (row_ff >= h);
      item.keep  = !(kind == KIND_FLUSH && !item.drain);

      // At the start of a row the right-edge pixel of the row two above is due.
      pre  = (col_ff == '0) && (row_ff >= DIM_W'(2));
      post = !pre && (col_ff >= DIM_W'(1)) && (row_ff >= DIM_W'(1));
      er   = pre ? row_ff - DIM_W'(2) : row_ff - DIM_W'(1);
      ec   = pre ? w - DIM_W'(1) : col_ff - DIM_W'(1);

      item.emit    = pre || post;
      item.rodd    = er[0];
      item.codd    = ec[0];
      item.top     = (er == '0);
      item.bottom  = (er >= h - DIM_W'(1));
      item.left    = (ec == '0);
      item.right   = (ec >= w - DIM_W'(1));
      item.eof     = item.emit && item.bottom && item.right;
      item.addr_ok = (32'(col_ff) < MAX_WIDTH);
      item.addr    = col_ff[ADDR_W-1:0];
      item.sample  = item.drain ? '0 : sample;

      wrap   = ({1'b0, col_ff} + (DIM_W+1)'(1)) >= {1'b0, w};
      row_in = row_ff;
      col_in = col_ff;
      if (accept && item.keep) begin
         if (item.eof) begin
            row_in = '0;
            col_in = '0;
         end else if (wrap) begin
            row_in = row_ff + DIM_W'(1);
            col_in = '0;
         end else begin
            col_in = col_ff + DIM_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

endmodule

### rtl/core/bbd_interp.sv
// Line stores, 3x3 window and bilinear interpolation with the result register.
// Depends on bbd_pkg and bbd_ram.
module bbd_interp (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  bbd_pkg::item_type item,
   output logic              ready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [23:0]       rsp_tdata,   // red_out, green_out, blue_out
   output logic              rsp_tlast    // end_of_frame
);
   import bbd_pkg::*;

   logic              b_valid_ff, b_valid_in;
   item_type          b_item_ff;
   logic              b_fire;
   logic [LINE_W-1:0] line_rd;
   pix_type           up, mid;
   win_type           win_ff, win_next;
   logic              out_valid_ff, out_valid_in;
   pix_type           red_ff, green_ff, blue_ff;
   logic              last_ff;
   pix_type           red_in, green_in, blue_in;

   // Upper row store in the high byte, middle row store in the low byte.
   bbd_ram #(
      .WIDTH (LINE_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (b_fire && b_item_ff.addr_ok),
      .wr_addr (b_item_ff.addr),
      .wr_data ({mid, b_item_ff.sample}),
      .rd_en   (load),
      .rd_addr (item.addr),
      .rd_data (line_rd)
   );

   function automatic pix_type px(input win_type win, input item_type it,
                                  input int dr, input int dc);
      int r;
      int c;
      r = dr;
      c = dc;
      if (r < 0 && it.top) r = 1;
      if (r > 0 && it.bottom) r = -1;
      if (c < 0 && it.left) c = 1;
      if (c > 0 && it.right) c = -1;
      return win[2'(c + 1)][2'(r + 1)];
   endfunction

   assign b_fire = b_valid_ff && (!b_item_ff.emit || !out_valid_ff || rsp_tready);
   assign ready  = !b_valid_ff || b_fire;

   always_comb begin
      pix_type  pc, pu, pd, pl, pr, pul, pur, pdl, pdr;
      logic [8:0] s_ud, s_lr, s_rr;
      logic [9:0] s_cross, s_diag;

      up  = b_item_ff.addr_ok ? line_rd[LINE_W-1:PIX_W] : '0;
      mid = b_item_ff.addr_ok ? line_rd[PIX_W-1:0] : '0;

      win_next[0] = win_ff[1];
      win_next[1] = win_ff[2];
      win_next[2] = {b_item_ff.sample, mid, up};

      // The shifted window always centers the due pixel in column one, also for
      // the right-edge pixel, whose right neighbor is repaired to the left one.
      pc  = px(win_next, b_item_ff, 0, 0);
      pu  = px(win_next, b_item_ff, -1, 0);
      pd  = px(win_next, b_item_ff, 1, 0);
      pl  = px(win_next, b_item_ff, 0, -1);
      pr  = px(win_next, b_item_ff, 0, 1);
      pul = px(win_next, b_item_ff, -1, -1);
      pur = px(win_next, b_item_ff, -1, 1);
      pdl = px(win_next, b_item_ff, 1, -1);
      pdr = px(win_next, b_item_ff, 1, 1);

      s_ud    = {1'b0, pu} + {1'b0, pd};
      s_lr    = {1'b0, pl} + {1'b0, pr};
      s_rr    = {1'b0, pur} + {1'b0, pdr};
      s_cross = {1'b0, s_ud} + {1'b0, s_lr};
      s_diag  = {2'b0, pul} + {2'b0, pur} + {2'b0, pdl} + {2'b0, pdr};

      if (b_item_ff.rodd) begin
         if (b_item_ff.codd) red_in = s_ud[8:1];
         else if (!b_item_ff.left) red_in = s_diag[9:2];
         else red_in = s_rr[8:1];
      end else begin
         if (b_item_ff.codd) red_in = pc;
         else if (!b_item_ff.left) red_in = s_lr[8:1];
         else red_in = pr;
      end

      if (b_item_ff.rodd == b_item_ff.codd) green_in = pc;
      else if (b_item_ff.top) green_in = s_lr[8:1];
      else if (b_item_ff.left) green_in = s_ud[8:1];
      else green_in = s_cross[9:2];

      if (b_item_ff.rodd) begin
         if (b_item_ff.codd) blue_in = s_lr[8:1];
         else blue_in = pc;
      end else begin
         if (b_item_ff.codd) blue_in = s_diag[9:2];
         else blue_in = s_ud[8:1];
      end

      if (load) b_valid_in = 1'b1;
      else if (b_fire) b_valid_in = 1'b0;
      else b_valid_in = b_valid_ff;

      if (b_fire && b_item_ff.emit) out_valid_in = 1'b1;
      else if (rsp_tready) out_valid_in = 1'b0;
      else out_valid_in = out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
         win_ff       <= '0;
      end else begin
         b_valid_ff   <= b_valid_in;
         out_valid_ff <= out_valid_in;
         if (b_fire) begin
            win_ff <= win_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         b_item_ff <= item;
      end
      if (b_fire && b_item_ff.emit) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
         last_ff  <= b_item_ff.eof;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {blue_ff, green_ff, red_ff};
   assign rsp_tlast  = last_ff;

endmodule

### rtl/core/bayer_bilinear_demosaic_top.sv
// Top level of the bilinear GRBG Bayer demosaic: control registers, position
// tracking and the interpolation pipeline. Depends on bbd_pkg, bbd_ctrl, bbd_interp.
//
// Raw 8-bit samples of a GRBG frame enter on the req_ stream in raster order
// (tuser = 0); each produces the RGB pixel one row and one column behind it on
// the rsp_ stream, with tlast marking the last pixel of the frame. After the
// last sample of a frame, flush requests (tuser = 1) drain the remaining row
// plus one pixel; flush requests at any other time are dropped, and raw
// samples sent once the frame is fully input act as flushes.
// A request is taken every cycle while no pixel waits on a stalled receiver. A pixel
// reaches rsp_tvalid after its request passes the line store read and then the
// window shift and the interpolation into the result register.
// When the receiver stalls, the result register holds and one more request can
// enter the line store stage; then req_tready drops until the pixel is taken.
// Frame size is set through the csr_ port (width at 0x0, height at 0x4) while
// the stream is idle. Reset clears the position counters, the window and the
// pipeline valid bits and sets the size to 640 x 480; line store contents are
// left as they are, since rows above the frame never reach an output.
module bayer_bilinear_demosaic_top (
   input  logic        clock,
   input  logic        reset,
   // Request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // sample
   input  logic        req_tuser,    // kind
   // Result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,    // red_out, green_out, blue_out
   output logic        rsp_tlast,    // end_of_frame
   // Control registers
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import bbd_pkg::*;

   dim_type  width_ff, height_ff;
   logic     csr_wr;
   logic     accept;
   logic     load;
   item_type item;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_FRAME_HEIGHT) ? {20'b0, height_ff}
                                                          : {20'b0, width_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_W'(640);
         height_ff <= DIM_W'(480);
      end else if (csr_wr) begin
         if (csr_paddr[2] == REG_FRAME_WIDTH) width_ff <= csr_pwdata[DIM_W-1:0];
         else height_ff <= csr_pwdata[DIM_W-1:0];
      end
   end

   assign accept = req_tvalid && req_tready;
   assign load   = accept && item.keep;

   bbd_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .frame_width  (width_ff),
      .frame_height (height_ff),
      .accept       (accept),
      .kind         (req_tuser),
      .sample       (req_tdata),
      .item         (item)
   );

   bbd_interp u_interp (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .item       (item),
      .ready      (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // Requests are held back only by a pixel waiting on a stalled receiver.
   a_ready_only_on_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("request side blocked without a stalled result");

   // After the last pixel of a frame the position restarts at the top left.
   a_eof_restarts: assert property (@(posedge clock) disable iff (reset)
      (load && item.eof) |=> (!item.emit && !item.drain))
      else $error("position not restarted after end of frame");

   // The end of frame can only be flagged on a request that emits a pixel.
   a_eof_needs_pixel: assert property (@(posedge clock) disable iff (reset)
      item.eof |-> item.emit)
      else $error("end of frame without a pixel");

endmodule

### bench/bayer_bilinear_demosaic_top_test.sv
// Self-checking bench for the bilinear GRBG Bayer demosaic top level.
// Predicts every RGB pixel from the raw request stream and checks the result stream.
// Depends on bbd_pkg and bayer_bilinear_demosaic_top.
`timescale 1ns / 100ps

module bayer_bilinear_demosaic_top_test;
   import bbd_pkg::*;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int HOLD_CYCLES  = 400;
   localparam int SETTLE_TICKS = 8;
   localparam int PHASE_ITEMS  = 185;

   typedef struct packed {
      pix_type red;
      pix_type green;
      pix_type blue;
      logic    last;
   } pixel_type;

   // Tracks the raster position, line stores and 3x3 window, and keeps the
   // pixels still owed by the block in arrival order.
   class pixel_scoreboard;
      int         width_px = 640;
      int         height_px = 480;
      int         failures = 0;
      bit [7:0]   upper_line [MAX_WIDTH];
      bit [7:0]   middle_line [MAX_WIDTH];
      bit [7:0]   win [9];      // win[col * 3 + row], col 0 is the left, row 0 the top
      int         in_row = 0;
      int         in_col = 0;
      bit         at_top, at_bottom, at_left, at_right;
      int         shift;
      pixel_type  pixels_due [$];

      function int clamp(logic [11:0] v, int maxv);
         if (v < 2) return 2;
         if (v > maxv) return maxv;
         return v;
      endfunction

      function void set_register(logic index, logic [11:0] value);
         if (index == REG_FRAME_WIDTH) begin
            width_px = clamp(value, MAX_WIDTH);
         end else begin
            height_px = clamp(value, MAX_HEIGHT);
         end
      endfunction

      function int pending();
         return pixels_due.size();
      endfunction

      // Neighbor at (dr, dc) of the center, with missing neighbors mirrored.
      function int pick(int dr, int dc);
         int r, c;
         if (dr < 0 && at_top) dr = 1;
         if (dr > 0 && at_bottom) dr = -1;
         if (dc < 0 && at_left) dc = 1;
         if (dc > 0 && at_right) dc = -1;
         r = dr + 1;
         c = dc + 1 + shift;
         if (c < 0) c = 0;
         if (c > 2) c = 2;
         return win[c * 3 + r];
      endfunction

      function pixel_type interpolate(int er, int ec, int w, int h, int base);
         pixel_type p;
         bit rodd, codd;
         int rv, gv, bv;
         rodd = (er % 2) != 0;
         codd = (ec % 2) != 0;
         shift = base;
         at_top = (er == 0);
         at_bottom = (er >= h - 1);
         at_left = (ec == 0);
         at_right = (ec >= w - 1);
         if (rodd) begin
            if (codd) rv = (pick(-1, 0) + pick(1, 0)) >> 1;
            else if (ec != 0) rv = (pick(-1, -1) + pick(-1, 1) + pick(1, -1) + pick(1, 1)) >> 2;
            else rv = (pick(-1, 1) + pick(1, 1)) >> 1;
         end else begin
            if (codd) rv = pick(0, 0);
            else if (ec != 0) rv = (pick(0, -1) + pick(0, 1)) >> 1;
            else rv = pick(0, 1);
         end
         if (rodd == codd) gv = pick(0, 0);
         else if (er == 0) gv = (pick(0, -1) + pick(0, 1)) >> 1;
         else if (ec == 0) gv = (pick(-1, 0) + pick(1, 0)) >> 1;
         else gv = (pick(-1, 0) + pick(1, 0) + pick(0, -1) + pick(0, 1)) >> 2;
         if (rodd) begin
            if (codd) bv = (pick(0, -1) + pick(0, 1)) >> 1;
            else bv = pick(0, 0);
         end else begin
            if (codd) bv = (pick(-1, -1) + pick(-1, 1) + pick(1, -1) + pick(1, 1)) >> 2;
            else bv = (pick(-1, 0) + pick(1, 0)) >> 1;
         end
         p.red = rv[7:0];
         p.green = gv[7:0];
         p.blue = bv[7:0];
         p.last = at_bottom && at_right;
         return p;
      endfunction

      function void note_request(logic kind, pix_type sample);
         pix_type s, up, mid;
         pixel_type p;
         bit drain, got;
         int k;
         drain = (in_row >= height_px);
         // A flush is dropped unless the whole frame has been taken in.
         if (kind == KIND_FLUSH && !drain) return;
         s = drain ? 8'h00 : sample;
         got = 0;
         // At the start of a row the right-edge pixel of the row two above falls due.
         if (in_col == 0 && in_row >= 2) begin
            p = interpolate(in_row - 2, width_px - 1, width_px, height_px, 1);
            got = 1;
         end
         up = upper_line[in_col];
         mid = middle_line[in_col];
         upper_line[in_col] = mid;
         middle_line[in_col] = s;
         for (k = 0; k < 6; k++) win[k] = win[k + 3];
         win[6] = up;
         win[7] = mid;
         win[8] = s;
         if (!got && in_col >= 1 && in_row >= 1) begin
            p = interpolate(in_row - 1, in_col - 1, width_px, height_px, 0);
            got = 1;
         end
         if (in_col + 1 >= width_px) begin
            in_col = 0;
            in_row++;
         end else begin
            in_col++;
         end
         if (got) begin
            pixels_due.push_back(p);
            if (p.last) begin
               in_row = 0;
               in_col = 0;
            end
         end
      endfunction

      function void compare(string what, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            if (failures < 100) begin
               $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
            end
            failures++;
         end
      endfunction

      function void check_pixel(logic [23:0] data, logic last);
         pixel_type p;
         if (pixels_due.size() == 0) begin
            if (failures < 100) begin
               $display("%0t: pixel expected none, got %h last %b", $time, data, last);
            end
            failures++;
            return;
         end
         p = pixels_due.pop_front();
         compare("red", p.red, data[7:0]);
         compare("green", p.green, data[15:8]);
         compare("blue", p.blue, data[23:16]);
         compare("end of frame", {7'b0, p.last}, {7'b0, last});
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;    // sample
   logic        req_tuser = KIND_RAW; // kind
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;            // red_out, green_out, blue_out
   logic        rsp_tlast;            // end_of_frame
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = 3'b000;
   logic [31:0] csr_pwdata = 32'h0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   pixel_scoreboard sb;
   int          send_idle_pct = 0;
   int          stall_pct = 0;
   int          holds_asked = 0;
   int          holds_served = 0;
   int          hold_left = 0;
   int          phase_items = 0;
   int unsigned cycle_count = 0;

   bayer_bilinear_demosaic_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Receiver: random stalls, plus one long hold-off when the stimulus asks for it.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (holds_asked != holds_served) begin
         holds_served <= holds_served + 1;
         hold_left <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99, 0) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_pixel(rsp_tdata, rsp_tlast);
      end
   end

   task automatic send_request(input logic kind, input pix_type sample);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= sample;
      do @(posedge clock); while (!req_tready);
      sb.note_request(kind, sample);
   endtask

   task automatic write_reg(input logic index, input logic [11:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= {20'($urandom), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.set_register(index, value);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // Stop offering requests and let every owed pixel come out.
   task automatic wait_quiet();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   function automatic logic [11:0] pick_size(int top);
      int r;
      r = $urandom_range(99, 0);
      if (r < 5) return 12'($urandom_range(1, 0));
      if (r < 8) return 12'($urandom_range(24, 11));
      return 12'($urandom_range(top, 2));
   endfunction

   // One complete frame: raw samples with stray flushes, then the drain.
   task automatic run_frame(input logic [11:0] width_value, input logic [11:0] height_value);
      int i, w, h, pick;
      wait_quiet();
      write_reg(REG_FRAME_WIDTH, width_value);
      write_reg(REG_FRAME_HEIGHT, height_value);
      w = sb.width_px;
      h = sb.height_px;
      for (i = 0; i < w * h; i++) begin
         if ($urandom_range(99, 0) < 4) send_request(KIND_FLUSH, 8'($urandom));
         pick = $urandom_range(9, 0);
         send_request(KIND_RAW, (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom));
      end
      // Raw samples during the drain count as flushes.
      for (i = 0; i <= w; i++) begin
         send_request(($urandom_range(99, 0) < 20) ? KIND_RAW : KIND_FLUSH, 8'($urandom));
      end
      if ($urandom_range(99, 0) < 10) send_request(KIND_FLUSH, 8'($urandom));
      phase_items += w * h + w + 1;
   endtask

   task automatic run_phase(input int idle, input int stall, input bit with_hold);
      send_idle_pct = idle;
      stall_pct = stall;
      if (with_hold) holds_asked <= holds_asked + 1;
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) run_frame(pick_size(10), pick_size(6));
   endtask

   initial begin
      pix_type mix [9];
      int i;
      sb = new();
      mix = '{8'h55, 8'hAA, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h01, 8'h80, 8'hFE};
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Sizes below the minimum clamp to a 2 x 2 frame.
      write_reg(REG_FRAME_WIDTH, 12'd0);
      write_reg(REG_FRAME_HEIGHT, 12'd1);
      send_request(KIND_FLUSH, 8'hFF);   // flush while idle is dropped
      send_request(KIND_RAW, 8'h00);
      send_request(KIND_FLUSH, 8'h5A);   // flush before the frame is complete is dropped
      send_request(KIND_RAW, 8'hFF);
      send_request(KIND_RAW, 8'hFF);
      send_request(KIND_RAW, 8'h00);
      send_request(KIND_RAW, 8'hAA);     // raw sample after the frame acts as a flush
      send_request(KIND_FLUSH, 8'h00);
      send_request(KIND_FLUSH, 8'h00);
      send_request(KIND_FLUSH, 8'hFF);   // the frame has ended, so this is dropped
      wait_quiet();

      write_reg(REG_FRAME_WIDTH, 12'd3);
      write_reg(REG_FRAME_HEIGHT, 12'd3);
      for (i = 0; i < 9; i++) send_request(KIND_RAW, mix[i]);
      for (i = 0; i < 4; i++) send_request(KIND_FLUSH, 8'h00);

      run_phase(0, 0, 1);
      run_phase(77, 0, 0);
      run_phase(0, 77, 0);
      run_phase(17, 17, 0);

      wait_quiet();
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
